// ===== src/base64_stream_encoder_top_macros.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define B64E_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/b64e_pkg.sv =====
package b64e_pkg;

  localparam int unsigned Q_DEPTH = 4;

  localparam logic [1:0] PH_ZERO = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_LB   = 8'h62;
  localparam logic [7:0] CH_PAD  = 8'h3D;

  // One queue entry: the symbols that one byte completes plus padding to append.
  typedef struct packed {
    logic [5:0] sym0;
    logic [5:0] sym1;
    logic       two_sym;
    logic [1:0] pad_cnt;
    logic       last;
  } b64e_entry_t;

  function automatic logic [7:0] b64e_sym_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      ch = 8'h61 + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      ch = 8'h30 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      ch = CH_PLUS;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== src/b64e_queue.sv =====
`include "base64_stream_encoder_top_macros.svh"

module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64e_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_vld,
  output b64e_entry_t head_entry
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64e_entry_t      mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_vld   = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `B64E_ASSERT_IMP(a_q_no_overflow, full, !push, "queue written while full")
  `B64E_ASSERT_IMP(a_q_no_underflow, !head_vld, !pop, "queue read while empty")

endmodule

// ===== src/b64e_front.sv =====
`include "base64_stream_encoder_top_macros.svh"

module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        q_full,
  output logic        q_push,
  output b64e_entry_t q_entry
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Split the byte into the symbols it completes; carry the rest to the next word.
  always_comb begin
    q_entry   = '0;
    phase_nxt = PH_ZERO;
    left_nxt  = '0;
    q_entry.last = in_last_byte;
    case (phase_r)
      PH_ONE: begin
        q_entry.sym0 = {left_r[1:0], in_data_byte[7:4]};
        if (in_last_byte) begin
          q_entry.sym1    = {in_data_byte[3:0], 2'b00};
          q_entry.two_sym = 1'b1;
          q_entry.pad_cnt = 2'd1;
        end else begin
          phase_nxt = PH_TWO;
          left_nxt  = in_data_byte[3:0];
        end
      end
      PH_TWO: begin
        q_entry.sym0    = {left_r[3:0], in_data_byte[7:6]};
        q_entry.sym1    = in_data_byte[5:0];
        q_entry.two_sym = 1'b1;
      end
      default: begin
        q_entry.sym0 = in_data_byte[7:2];
        if (in_last_byte) begin
          q_entry.sym1    = {in_data_byte[1:0], 4'b0000};
          q_entry.two_sym = 1'b1;
          q_entry.pad_cnt = 2'd2;
        end else begin
          phase_nxt = PH_ONE;
          left_nxt  = {2'b00, in_data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ZERO;
      left_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  `B64E_ASSERT_IMP(a_fr_group_start_clean, phase_r == PH_ZERO, left_r == 4'd0, "leftover bits at group start")
  `B64E_ASSERT_IMP(a_fr_phase1_two_bits, phase_r == PH_ONE, left_r[3:2] == 2'b00, "phase one keeps more than two bits")

endmodule

// ===== src/b64e_back.sv =====
`include "base64_stream_encoder_top_macros.svh"

module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        esc_mode,
  input  logic        head_vld,
  input  b64e_entry_t head_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam logic [1:0] ESC_PCT = 2'd0;
  localparam logic [1:0] ESC_TWO = 2'd1;
  localparam logic [1:0] ESC_LB  = 2'd2;

  logic [1:0] unit_r, unit_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic [2:0] n_units;
  logic       is_sym;
  logic [5:0] sym_idx;
  logic [7:0] sym_ch;
  logic       escaping;
  logic [7:0] cur_ch;
  logic       unit_done;
  logic       entry_done;
  logic       advance;

  assign n_units  = (head_entry.two_sym ? 3'd2 : 3'd1) + {1'b0, head_entry.pad_cnt};
  assign is_sym   = (unit_r == 2'd0) || (unit_r == 2'd1 && head_entry.two_sym);
  assign sym_idx  = (unit_r == 2'd0) ? head_entry.sym0 : head_entry.sym1;
  assign sym_ch   = b64e_sym_char(sym_idx);
  assign escaping = is_sym && esc_mode && (sym_ch == CH_PLUS);

  always_comb begin
    if (escaping) begin
      case (esc_r)
        ESC_PCT: cur_ch = CH_PCT;
        ESC_TWO: cur_ch = CH_TWO;
        default: cur_ch = CH_LB;
      endcase
    end else if (is_sym) begin
      cur_ch = sym_ch;
    end else begin
      cur_ch = CH_PAD;
    end
  end

  assign unit_done  = !escaping || (esc_r == ESC_LB);
  assign entry_done = unit_done && ({1'b0, unit_r} == n_units - 3'd1);
  // Advance when an entry is waiting and the output register is free or drains this cycle.
  assign advance    = head_vld && (!out_valid_r || !out_stall);
  assign q_pop      = advance && entry_done;

  always_comb begin
    unit_nxt = unit_r;
    esc_nxt  = esc_r;
    if (advance) begin
      esc_nxt = unit_done ? ESC_PCT : esc_r + 2'd1;
      if (entry_done) begin
        unit_nxt = '0;
      end else if (unit_done) begin
        unit_nxt = unit_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r      <= '0;
      esc_r       <= ESC_PCT;
      out_valid_r <= 1'b0;
    end else begin
      unit_r <= unit_nxt;
      esc_r  <= esc_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= cur_ch;
      out_last_r <= head_entry.last && entry_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `B64E_ASSERT_IMP(a_bk_esc_only_on_plus, esc_r != ESC_PCT, head_vld && escaping, "escape step without a plus")
  `B64E_ASSERT_NXT(a_bk_hold_when_stalled, out_valid_r && out_stall, out_valid_r && $stable(out_char_r), "output word changed under stall")

endmodule

// ===== src/base64_stream_encoder_top.sv =====
// The first character of a byte passes through the queue and then the output register.
// Throughput: one character per cycle while out_stall is low; a byte yields 1 to 4
//   characters, up to 6 with escaped plus signs.
// A 4-entry queue between byte classification and character emission absorbs bursts.
// Reset (rst_n low, synchronous): group position, leftover bits, queue and output
//   register cleared; escape mode off.
module base64_stream_encoder_top import b64e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_escape_plus_mode
);

  logic        esc_mode_r;
  logic        q_full;
  logic        q_push;
  b64e_entry_t q_entry;
  logic        q_pop;
  logic        head_vld;
  b64e_entry_t head_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      esc_mode_r <= cfg_escape_plus_mode;
    end
  end

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_vld   (head_vld),
    .head_entry (head_entry)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .esc_mode   (esc_mode_r),
    .head_vld   (head_vld),
    .head_entry (head_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

// ===== dv/base64_stream_encoder_checker.sv =====
module base64_stream_encoder_checker import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_escape_plus_mode,
  output int         fail_count,
  output int         pending_chars
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64_char_t  expected_chars[$];
  b64_char_t  want;
  logic       escape_plus;
  logic [1:0] group_pos;
  logic [3:0] carry_bits;

  task automatic emit_raw(input logic [7:0] c);
    expected_chars.push_back('{c, 1'b0});
  endtask

  task automatic emit_sym(input logic [5:0] idx);
    logic [7:0] c;
    c = b64_alphabet[idx];
    if (c == CH_PLUS && escape_plus) begin
      emit_raw(CH_PCT);
      emit_raw(CH_TWO);
      emit_raw(CH_LB);
    end else begin
      emit_raw(c);
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic is_last);
    b64_char_t tail;
    case (group_pos)
      PH_ONE: begin
        emit_sym({carry_bits[1:0], b[7:4]});
        if (is_last) begin
          emit_sym({b[3:0], 2'b00});
          emit_raw(CH_PAD);
          group_pos  = PH_ZERO;
          carry_bits = 4'd0;
        end else begin
          group_pos  = PH_TWO;
          carry_bits = b[3:0];
        end
      end
      PH_TWO: begin
        emit_sym({carry_bits, b[7:6]});
        emit_sym(b[5:0]);
        group_pos  = PH_ZERO;
        carry_bits = 4'd0;
      end
      default: begin
        emit_sym(b[7:2]);
        if (is_last) begin
          emit_sym({b[1:0], 4'b0000});
          emit_raw(CH_PAD);
          emit_raw(CH_PAD);
          group_pos  = PH_ZERO;
          carry_bits = 4'd0;
        end else begin
          group_pos  = PH_ONE;
          carry_bits = {2'b00, b[1:0]};
        end
      end
    endcase
    // mark the final character of the message
    if (is_last) begin
      tail = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_chars = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      escape_plus = 1'b0;
      group_pos   = PH_ZERO;
      carry_bits  = 4'd0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected char %h last %b with nothing pending", out_char, out_last);
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== out_char || want.last !== out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.ch, want.last, out_char, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        escape_plus = cfg_escape_plus_mode;
      if (in_valid && !in_stall)
        encode_byte(in_data_byte, in_last_byte);
    end
    pending_chars = expected_chars.size();
  end

endmodule

// ===== dv/base64_stream_encoder_top_test.sv =====
module base64_stream_encoder_top_test;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_escape_plus_mode;
  int         fail_count;
  int         pending_chars;
  int         in_idle_pct;
  int         out_idle_pct;
  int         hold_len;

  base64_stream_encoder_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_char             (out_char),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_escape_plus_mode (cfg_escape_plus_mode)
  );

  base64_stream_encoder_checker char_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_char             (out_char),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_escape_plus_mode (cfg_escape_plus_mode),
    .fail_count           (fail_count),
    .pending_chars        (pending_chars)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("base64_stream_encoder_top test failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Bias toward bytes that land on the plus sign in each group position.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'hFB;
      1:       return 8'hEF;
      2:       return 8'hBE;
      3:       return 8'hF8;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_messages(input int n_words);
    int   sent;
    int   len;
    logic broken;
    sent = 0;
    while (sent < n_words) begin
      len    = $urandom_range(1, 10);
      broken = ($urandom_range(99) < 15);
      for (int k = 0; k < len; k++) begin
        send_byte(pick_byte(), broken ? 1'($urandom_range(1)) : (k == len - 1));
        sent++;
      end
    end
  endtask

  // Drop valid and hold until every pending char has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chars != 0) @(negedge clk);
  endtask

  task automatic write_escape(input logic mode);
    cfg_valid            <= 1'b1;
    cfg_escape_plus_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_data_byte         = 8'd0;
    in_last_byte         = 1'b0;
    cfg_valid            = 1'b0;
    cfg_escape_plus_mode = 1'b0;
    in_idle_pct          = 0;
    out_idle_pct         = 0;
    hold_len             = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // plain mode: single and double trailing bytes, full groups, extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b1);
    drain();
    write_escape(1'b1);

    // escaped plus signs in every slot, last on an escaped char
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b1);

    for (int r = 0; r < 3; r++) begin
      in_idle_pct  = (r == 0) ? 16 : (r == 1) ? 62 : 0;
      out_idle_pct = (r == 0) ? 62 : (r == 1) ? 16 : 0;
      drain();
      write_escape(1'b0);
      if (r == 0) begin
        @(posedge clk);
        hold_len = 80;
        @(negedge clk);
      end
      send_messages(60);
      drain();
      write_escape(1'b1);
      send_messages(60);
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("base64_stream_encoder_top test passed");
    end else begin
      $display("base64_stream_encoder_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/b64e_pkg.sv
src/b64e_queue.sv
src/b64e_front.sv
src/b64e_back.sv
src/base64_stream_encoder_top.sv
dv/base64_stream_encoder_checker.sv
dv/base64_stream_encoder_top_test.sv
